### hdl/rbmp_pkg.sv
// Shared types and constants for the rigid body mass properties block.
package rbmp_pkg;

  // Field widths of one particle and of one result.
  localparam int unsigned FieldW   = 16;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 328;
  localparam int unsigned MassOutW = 24;
  localparam int unsigned UsedOutW = 9;
  localparam int unsigned InertiaW = 64;

  // Reciprocal of five: floor(v * Recip5 / 2^Recip5Shift) equals v / 5 for any 32-bit v.
  localparam logic [31:0] Recip5      = 32'hCCCC_CCCD;
  localparam int unsigned Recip5Shift = 34;

  // Saturation limits of the result fields.
  localparam logic [MassOutW-1:0] MassMax = '1;
  localparam logic [UsedOutW-1:0] UsedMax = '1;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIVX  = 5'b00010,
    ST_DIVY  = 5'b00100,
    ST_PASS  = 5'b01000,
    ST_DRAIN = 5'b10000
  } back_state_e;

endpackage

### hdl/rigid_body_mass_properties.sv
// Top level of the planar rigid body mass properties block.
// Particles stream in at one per cycle while tready is high, and the front end stores them
// and sums mass and mass-weighted position. The particle marked tlast closes the body; the
// front end then holds tready low until the back end has read the store out. The back end
// divides the two weighted sums by the mass on a shared one-bit-per-cycle divider, walks
// the stored particles at one per cycle through a six-stage pipeline and then presents one
// result. No clearing pass is needed after reset.
module rigid_body_mass_properties #(
  parameter int unsigned MAX_PARTICLES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // particle_mass, pos_x, pos_y, particle_radius
  input  logic [rbmp_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // total_mass, centroid_x, centroid_y, inertia_xx, inertia_yy, inertia_zz, inertia_xy,
  // particles_used, overflowed, zero fill
  output logic [rbmp_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rbmp_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned MSW = 16 + CW;
  localparam int unsigned WSW = 33 + CW;
  localparam int unsigned JW  = CW + MSW + 2 * WSW + 1;

  logic           job_push, job_pop, job_full, job_empty, release_w;
  logic [CW-1:0]  f_count, b_count;
  logic [MSW-1:0] f_msum, b_msum;
  logic [WSW-1:0] f_wx, f_wy, b_wx, b_wy;
  logic           f_drop, b_drop;
  logic [JW-1:0]  job_wdata, job_rdata;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [InDataW-1:0] ram_rdata;

  rbmp_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .release_i       (release_w),
    .job_full_i      (job_full),
    .job_push_o      (job_push),
    .job_count_o     (f_count),
    .job_msum_o      (f_msum),
    .job_wx_o        (f_wx),
    .job_wy_o        (f_wy),
    .job_drop_o      (f_drop),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr)
  );

  rbmp_ram #(.WIDTH(InDataW), .DEPTH(MAX_PARTICLES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign job_wdata = {f_drop, f_wy, f_wx, f_msum, f_count};
  assign {b_drop, b_wy, b_wx, b_msum, b_count} = job_rdata;

  rbmp_fifo #(.WIDTH(JW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  rbmp_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_empty_i     (job_empty),
    .job_pop_o       (job_pop),
    .job_count_i     (b_count),
    .job_msum_i      (b_msum),
    .job_wx_i        (b_wx),
    .job_wy_i        (b_wy),
    .job_drop_i      (b_drop),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .release_o       (release_w),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  // The front end never pushes a body into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !job_full)
    else $error("body pushed into full queue");

  // The back end only takes a body that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> !job_empty)
    else $error("body popped from empty queue");

  // After a body closes, no particle is taken until the store has been read out.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |=> !s_axis_tready_o)
    else $error("front end ready while the store is still in use");
`endif

endmodule

### hdl/rbmp_ram.sv
// Generic single-port-write, registered-read RAM.
module rbmp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/rbmp_fifo.sv
// Two-entry queue that carries finished body sums from the front end to the back end.
module rbmp_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       fill_q, fill_d;

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push_i && pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = entry_q[rptr_q];
  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);

endmodule

### hdl/rbmp_div.sv
// Restoring divider, one quotient bit per cycle, for the centroid.
module rbmp_div #(
  parameter int unsigned NW = 41,
  parameter int unsigned DW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_q;
  logic [DW-1:0]   den_q;
  logic [DW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [DW:0]     trial;
  logic            ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, num_q[NW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

### hdl/rbmp_front.sv
// Front end: takes particles, stores them and sums mass and weighted position.
module rbmp_front #(
  parameter int unsigned MAX_PARTICLES = 256,
  localparam int unsigned CW  = $clog2(MAX_PARTICLES + 1),
  localparam int unsigned AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
  localparam int unsigned MSW = 16 + CW,
  localparam int unsigned WSW = 33 + CW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rbmp_pkg::InDataW-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  input  logic                         release_i,
  input  logic                         job_full_i,
  output logic                         job_push_o,
  output logic [CW-1:0]                job_count_o,
  output logic [MSW-1:0]               job_msum_o,
  output logic [WSW-1:0]               job_wx_o,
  output logic [WSW-1:0]               job_wy_o,
  output logic                         job_drop_o,
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o
);
  import rbmp_pkg::*;

  logic [CW-1:0]  count_q, count_d;
  logic [MSW-1:0] msum_q, msum_d;
  logic [WSW-1:0] wx_q, wx_d;
  logic [WSW-1:0] wy_q, wy_d;
  logic           drop_q, drop_d;
  logic           busy_q;
  logic           accept;
  logic           room;
  logic [FieldW-1:0] mass;
  logic signed [FieldW-1:0] px, py;
  logic signed [FieldW*2:0] mx, my;

  assign mass = s_axis_tdata_i[15:0];
  assign px   = s_axis_tdata_i[31:16];
  assign py   = s_axis_tdata_i[47:32];
  assign mx   = $signed({1'b0, mass}) * px;
  assign my   = $signed({1'b0, mass}) * py;

  // The store is shared with the back end, so a new body waits until it has read out.
  assign s_axis_tready_o = !busy_q && !job_full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign room            = (count_q < CW'(MAX_PARTICLES));

  // Running sums including the item being accepted.
  always_comb begin
    count_d = count_q;
    msum_d  = msum_q;
    wx_d    = wx_q;
    wy_d    = wy_q;
    drop_d  = drop_q;
    if (accept) begin
      if (room) begin
        count_d = count_q + 1'b1;
        msum_d  = msum_q + MSW'(mass);
        wx_d    = wx_q + WSW'(mx);
        wy_d    = wy_q + WSW'(my);
      end else begin
        drop_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      msum_q  <= '0;
      wx_q    <= '0;
      wy_q    <= '0;
      drop_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      if (accept && s_axis_tlast_i) begin
        count_q <= '0;
        msum_q  <= '0;
        wx_q    <= '0;
        wy_q    <= '0;
        drop_q  <= 1'b0;
        busy_q  <= 1'b1;
      end else begin
        count_q <= count_d;
        msum_q  <= msum_d;
        wx_q    <= wx_d;
        wy_q    <= wy_d;
        drop_q  <= drop_d;
        if (release_i) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign job_push_o  = accept && s_axis_tlast_i;
  assign job_count_o = count_d;
  assign job_msum_o  = msum_d;
  assign job_wx_o    = wx_d;
  assign job_wy_o    = wy_d;
  assign job_drop_o  = drop_d;
  assign ram_we_o    = accept && room;
  assign ram_waddr_o = count_q[AW-1:0];

endmodule

### hdl/rbmp_back.sv
// Back end: divides out the centroid, walks the store and sums the inertia tensor.
module rbmp_back #(
  parameter int unsigned MAX_PARTICLES = 256,
  localparam int unsigned CW  = $clog2(MAX_PARTICLES + 1),
  localparam int unsigned AW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
  localparam int unsigned MSW = 16 + CW,
  localparam int unsigned WSW = 33 + CW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_empty_i,
  output logic                          job_pop_o,
  input  logic [CW-1:0]                 job_count_i,
  input  logic [MSW-1:0]                job_msum_i,
  input  logic [WSW-1:0]                job_wx_i,
  input  logic [WSW-1:0]                job_wy_i,
  input  logic                          job_drop_i,
  output logic                          ram_re_o,
  output logic [AW-1:0]                 ram_raddr_o,
  input  logic [rbmp_pkg::InDataW-1:0]  ram_rdata_i,
  output logic                          release_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rbmp_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rbmp_pkg::*;

  localparam int unsigned SatW  = (MSW > MassOutW) ? MSW : MassOutW + 1;
  localparam int unsigned UsedW = (CW > UsedOutW) ? CW : UsedOutW + 1;

  back_state_e state_q, state_d;

  logic [CW-1:0]  cnt_q;
  logic [MSW-1:0] msum_q;
  logic [WSW-1:0] wx_q, wy_q;
  logic           drop_q;
  logic signed [FieldW-1:0] cx_q, cy_q;
  logic [CW-1:0]  addr_q;
  logic           last_addr;

  logic           div_start, div_done;
  logic [WSW-1:0] div_num, div_quot, div_sel, quot_signed;
  logic [MSW-1:0] div_den;
  logic signed [FieldW-1:0] cent;

  logic signed [InertiaW-1:0] ixx_q, iyy_q, izz_q, ixy_q;

  // Pass pipeline registers.
  logic        rv_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [15:0] m1_q, m2_q, m3_q;
  logic signed [16:0] dx1_q, dy1_q;
  logic [31:0] r2_1_q, r2_2_q;
  logic [29:0] a2_q;
  logic [32:0] dx2_2_q, dy2_2_q;
  logic signed [33:0] dxdy2_q;
  logic [2:0]  b3_q;
  logic [45:0] ma3_q, ma4_q, ma5_q;
  logic [48:0] mdx2_3_q, mdx2_4_q, mdx2_5_q;
  logic [48:0] mdy2_3_q, mdy2_4_q, mdy2_5_q;
  logic signed [50:0] mdxdy3_q, mdxdy4_q, mdxdy5_q;
  logic [20:0] v4_val_q;
  logic [18:0] q5_q;

  logic signed [16:0] dx_s, dy_s;
  logic signed [33:0] dx2_s, dy2_s, dxdy_s;
  logic [63:0] a_prod, q_prod;
  logic [31:0] five_a;
  logic [47:0] sphere;

  logic [SatW-1:0]  msum_ext;
  logic [UsedW-1:0] cnt_ext;
  logic [MassOutW-1:0] mass_out;
  logic [UsedOutW-1:0] used_out;
  logic pipe_busy;
  logic out_load;

  // Shared divider, x sum first and then y sum.
  assign div_sel = (state_q == ST_IDLE) ? job_wx_i : ((state_q == ST_DIVX) ? wy_q : wx_q);
  assign div_num = div_sel[WSW-1] ? WSW'(-div_sel) : div_sel;
  assign div_den = (state_q == ST_IDLE) ? job_msum_i : msum_q;
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i && !m_axis_tvalid_o;
  assign div_start = job_pop_o || ((state_q == ST_DIVX) && div_done);

  rbmp_div #(.NW(WSW), .DW(MSW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sign of the quotient follows the dividend; a zero mass gives a zero centroid.
  assign quot_signed = ((state_q == ST_DIVX) ? wx_q[WSW-1] : wy_q[WSW-1]) ?
                       WSW'(-div_quot) : div_quot;
  assign cent = (msum_q == '0) ? '0 : quot_signed[FieldW-1:0];

  assign last_addr = (addr_q == cnt_q - 1'b1);
  assign ram_re_o    = (state_q == ST_PASS);
  assign ram_raddr_o = addr_q[AW-1:0];
  assign release_o   = ((state_q == ST_PASS) && last_addr) ||
                       ((state_q == ST_DIVY) && div_done && (cnt_q == '0));
  assign pipe_busy   = rv_q || v1_q || v2_q || v3_q || v4_q || v5_q;
  assign out_load    = (state_q == ST_DRAIN) && !pipe_busy;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_pop_o) begin
          state_d = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          state_d = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          state_d = (cnt_q == '0) ? ST_DRAIN : ST_PASS;
        end
      end
      ST_PASS: begin
        if (last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      rv_q            <= 1'b0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      v3_q            <= 1'b0;
      v4_q            <= 1'b0;
      v5_q            <= 1'b0;
      addr_q          <= '0;
      m_axis_tvalid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= ram_re_o;
      v1_q    <= rv_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      if (state_q == ST_PASS) begin
        addr_q <= addr_q + 1'b1;
      end else begin
        addr_q <= '0;
      end
      if (out_load) begin
        m_axis_tvalid_o <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_axis_tvalid_o <= 1'b0;
      end
    end
  end

  // Body totals and centroid.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cnt_q  <= job_count_i;
      msum_q <= job_msum_i;
      wx_q   <= job_wx_i;
      wy_q   <= job_wy_i;
      drop_q <= job_drop_i;
    end
    if (div_done && (state_q == ST_DIVX)) begin
      cx_q <= cent;
    end
    if (div_done && (state_q == ST_DIVY)) begin
      cy_q <= cent;
    end
  end

  // Stage arithmetic.
  assign dx_s   = $signed({ram_rdata_i[31], ram_rdata_i[31:16]}) - $signed({cx_q[15], cx_q});
  assign dy_s   = $signed({ram_rdata_i[47], ram_rdata_i[47:32]}) - $signed({cy_q[15], cy_q});
  assign dx2_s  = dx1_q * dx1_q;
  assign dy2_s  = dy1_q * dy1_q;
  assign dxdy_s = dx1_q * dy1_q;
  assign a_prod = r2_1_q * Recip5;
  assign five_a = {a2_q, 2'b00} + {2'b00, a2_q};
  assign q_prod = {11'd0, v4_val_q} * Recip5;
  assign sphere = {ma5_q, 1'b0} + 48'(q5_q);

  always_ff @(posedge clk_i) begin
    // Offsets from the centroid and squared radius.
    m1_q   <= ram_rdata_i[15:0];
    dx1_q  <= dx_s;
    dy1_q  <= dy_s;
    r2_1_q <= ram_rdata_i[63:48] * ram_rdata_i[63:48];
    // Squares, products and r^2 / 5.
    m2_q    <= m1_q;
    r2_2_q  <= r2_1_q;
    a2_q    <= a_prod[63:Recip5Shift];
    dx2_2_q <= dx2_s[32:0];
    dy2_2_q <= dy2_s[32:0];
    dxdy2_q <= dxdy_s;
    // Mass-weighted terms; r^2 = 5a + b.
    m3_q     <= m2_q;
    b3_q     <= 3'(r2_2_q - five_a);
    ma3_q    <= m2_q * a2_q;
    mdx2_3_q <= m2_q * dx2_2_q;
    mdy2_3_q <= m2_q * dy2_2_q;
    mdxdy3_q <= $signed({1'b0, m2_q}) * dxdy2_q;
    // Sphere term is 2ma + (2mb) / 5.
    v4_val_q <= 21'({19'(m3_q) * 19'(b3_q), 1'b0});
    ma4_q    <= ma3_q;
    mdx2_4_q <= mdx2_3_q;
    mdy2_4_q <= mdy2_3_q;
    mdxdy4_q <= mdxdy3_q;
    q5_q     <= q_prod[52:Recip5Shift];
    ma5_q    <= ma4_q;
    mdx2_5_q <= mdx2_4_q;
    mdy2_5_q <= mdy2_4_q;
    mdxdy5_q <= mdxdy4_q;
  end

  // Tensor accumulators.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      ixx_q <= '0;
      iyy_q <= '0;
      izz_q <= '0;
      ixy_q <= '0;
    end else if (v5_q) begin
      ixx_q <= ixx_q + InertiaW'(sphere) + InertiaW'(mdy2_5_q);
      iyy_q <= iyy_q + InertiaW'(sphere) + InertiaW'(mdx2_5_q);
      izz_q <= izz_q + InertiaW'(sphere) + InertiaW'(mdx2_5_q) + InertiaW'(mdy2_5_q);
      ixy_q <= ixy_q - InertiaW'(mdxdy5_q);
    end
  end

  // Result register with saturated counts.
  assign msum_ext = SatW'(msum_q);
  assign cnt_ext  = UsedW'(cnt_q);
  assign mass_out = (msum_ext > SatW'(MassMax)) ? MassMax : msum_ext[MassOutW-1:0];
  assign used_out = (cnt_ext > UsedW'(UsedMax)) ? UsedMax : cnt_ext[UsedOutW-1:0];

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata_o <= {6'd0, drop_q, used_out, ixy_q, izz_q, iyy_q, ixx_q,
                         cy_q, cx_q, mass_out};
    end
  end

endmodule

### sim/tb.sv
// Self-checking testbench for the rigid body mass properties block.
`timescale 1ns / 1ps

module tb;
  import rbmp_pkg::*;

  localparam int unsigned Capacity = 256;

  // One body result as unpacked from the output stream.
  typedef struct {
    logic [23:0]        mass;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    longint             ixx;
    longint             iyy;
    longint             izz;
    longint             ixy;
    logic [8:0]         used;
    logic               ovf;
  } body_props_t;

  // One particle row of the directed table.
  typedef struct {
    logic [15:0] m;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] r;
    logic        last;
    bit          typed;
    body_props_t want;
  } particle_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                s_axis_tlast_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  rigid_body_mass_properties dut (.*);

  // Predictor state: stored particles and running sums of the open body.
  logic [63:0]  body_store [Capacity];
  int unsigned  open_count;
  longint       open_mass;
  longint       body_wx;
  longint       body_wy;
  bit           body_dropped;

  body_props_t  props_due [$];
  int unsigned  errors;
  int unsigned  bodies_seen;
  int unsigned  items_sent;
  int unsigned  sender_gap_pct;
  int unsigned  recv_stall_pct;
  logic         hold_go;
  particle_row_t rows [$];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Adds one accepted particle; returns 1 with the body properties on the last one.
  function automatic bit absorb_particle(input logic [15:0] m, input logic [15:0] x,
                                         input logic [15:0] y, input logic [15:0] r,
                                         input logic last, output body_props_t p);
    longint cx;
    longint cy;
    longint pm;
    longint dx;
    longint dy;
    longint pr;
    longint sph;
    if (open_count < Capacity) begin
      body_store[open_count] = {r, y, x, m};
      open_count++;
      open_mass += longint'(m);
      body_wx += longint'(m) * longint'($signed(x));
      body_wy += longint'(m) * longint'($signed(y));
    end else begin
      body_dropped = 1'b1;
    end
    if (!last) return 1'b0;
    cx = (open_mass == 0) ? 0 : body_wx / open_mass;
    cy = (open_mass == 0) ? 0 : body_wy / open_mass;
    p.ixx = 0;
    p.iyy = 0;
    p.izz = 0;
    p.ixy = 0;
    for (int i = 0; i < open_count; i++) begin
      pm = longint'(body_store[i][15:0]);
      dx = longint'($signed(body_store[i][31:16])) - cx;
      dy = longint'($signed(body_store[i][47:32])) - cy;
      pr = longint'(body_store[i][63:48]);
      sph = (2 * pm * (pr * pr)) / 5;
      p.ixx += sph + pm * dy * dy;
      p.iyy += sph + pm * dx * dx;
      p.izz += sph + pm * (dx * dx + dy * dy);
      p.ixy -= pm * (dx * dy);
    end
    p.mass = (open_mass > 64'hFFFFFF) ? 24'hFFFFFF : open_mass[23:0];
    p.cx = cx[15:0];
    p.cy = cy[15:0];
    p.used = open_count[8:0];
    p.ovf = body_dropped;
    open_count = 0;
    open_mass = 0;
    body_wx = 0;
    body_wy = 0;
    body_dropped = 1'b0;
    return 1'b1;
  endfunction

  // Offers one particle after a random gap and waits for it to be taken.
  task automatic send_particle(input logic [15:0] m, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] r,
                               input logic last, input bit typed, input body_props_t want);
    body_props_t p;
    while ($urandom_range(99) < sender_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r, y, x, m};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (absorb_particle(m, x, y, r, last, p)) props_due.push_back(typed ? want : p);
  endtask

  // Random particle content, with zero and full-scale masses and full-scale radii favored.
  task automatic send_random_body(input int unsigned n, input bit massless);
    body_props_t none;
    logic [15:0] m;
    logic [15:0] r;
    none = '{default: 0};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: m = 16'h0000;
        1: m = 16'hFFFF;
        2: m = 16'($urandom_range(1023));
        default: m = 16'($urandom);
      endcase
      r = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom);
      if (massless) m = 16'h0000;
      send_particle(m, 16'($urandom), 16'($urandom), r, i == n - 1, 1'b0, none);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off counted here on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && hold_left == 0) hold_left = 3000;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker: each item against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    body_props_t got;
    body_props_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.mass = m_axis_tdata_o[23:0];
      got.cx   = m_axis_tdata_o[39:24];
      got.cy   = m_axis_tdata_o[55:40];
      got.ixx  = m_axis_tdata_o[119:56];
      got.iyy  = m_axis_tdata_o[183:120];
      got.izz  = m_axis_tdata_o[247:184];
      got.ixy  = m_axis_tdata_o[311:248];
      got.used = m_axis_tdata_o[320:312];
      got.ovf  = m_axis_tdata_o[321];
      bodies_seen++;
      if (props_due.size() == 0) begin
        $display("%0t: unexpected result item, mass %0d", $time, got.mass);
        errors++;
      end else begin
        want = props_due.pop_front();
        if (got.mass !== want.mass) begin
          $display("%0t: total_mass exp %0d got %0d", $time, want.mass, got.mass);
          errors++;
        end
        if (got.cx !== want.cx) begin
          $display("%0t: centroid_x exp %0d got %0d", $time, want.cx, got.cx);
          errors++;
        end
        if (got.cy !== want.cy) begin
          $display("%0t: centroid_y exp %0d got %0d", $time, want.cy, got.cy);
          errors++;
        end
        if (got.ixx !== want.ixx) begin
          $display("%0t: inertia_xx exp %0d got %0d", $time, want.ixx, got.ixx);
          errors++;
        end
        if (got.iyy !== want.iyy) begin
          $display("%0t: inertia_yy exp %0d got %0d", $time, want.iyy, got.iyy);
          errors++;
        end
        if (got.izz !== want.izz) begin
          $display("%0t: inertia_zz exp %0d got %0d", $time, want.izz, got.izz);
          errors++;
        end
        if (got.ixy !== want.ixy) begin
          $display("%0t: inertia_xy exp %0d got %0d", $time, want.ixy, got.ixy);
          errors++;
        end
        if (got.used !== want.used) begin
          $display("%0t: particles_used exp %0d got %0d", $time, want.used, got.used);
          errors++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t: overflowed exp %0b got %0b", $time, want.ovf, got.ovf);
          errors++;
        end
      end
    end
  end

  // Directed table row helpers.
  function automatic particle_row_t row(input int m, input int x, input int y, input int r,
                                        input bit last);
    particle_row_t t;
    t.m = 16'(m);
    t.x = 16'(x);
    t.y = 16'(y);
    t.r = 16'(r);
    t.last = last;
    t.typed = 1'b0;
    t.want = '{default: 0};
    return t;
  endfunction

  function automatic particle_row_t typed_row(input particle_row_t t, input int mass,
                                              input int cx, input int cy, input int used);
    t.typed = 1'b1;
    t.want.mass = 24'(mass);
    t.want.cx = 16'(cx);
    t.want.cy = 16'(cy);
    t.want.used = 9'(used);
    return t;
  endfunction

  // Main sequence.
  initial begin
    int unsigned n;
    errors = 0;
    bodies_seen = 0;
    items_sent = 0;
    open_count = 0;
    open_mass = 0;
    body_wx = 0;
    body_wy = 0;
    body_dropped = 1'b0;
    sender_gap_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty particle, unit particle, extremes, a massless body.
    rows.push_back(typed_row(row(0, 0, 0, 0, 1), 0, 0, 0, 1));
    rows.push_back(typed_row(row(256, 256, -256, 0, 1), 256, 256, -256, 1));
    rows.push_back(row(65535, 32767, -32768, 65535, 0));
    rows.push_back(row(65535, -32768, 32767, 65535, 1));
    rows.push_back(row(0, 100, 200, 300, 0));
    rows.push_back(typed_row(row(0, -5, 7, 9, 1), 0, 0, 0, 2));
    rows.push_back(row(1, 1, 1, 1, 0));
    rows.push_back(row(3, -1, -1, 65535, 0));
    rows.push_back(row(40000, 12345, -12345, 1, 0));
    rows.push_back(row(7, 0, 0, 0, 1));
    rows.push_back(row(65535, 0, 0, 65535, 1));
    rows.push_back(row(1, -32768, -32768, 0, 0));
    rows.push_back(row(2, 32767, 32767, 0, 1));
    rows.push_back(row(5, -3, 3, 2, 0));
    rows.push_back(row(5, 3, -3, 2, 1));
    foreach (rows[i])
      send_particle(rows[i].m, rows[i].x, rows[i].y, rows[i].r, rows[i].last,
                    rows[i].typed, rows[i].want);

    // Random bodies over the idling phases, with full and overfull stores.
    for (int ph = 0; ph < 4; ph++) begin
      sender_gap_pct = (ph == 1) ? 45 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 34 : 0;
      if (ph == 1) begin
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      if (ph == 0) send_random_body(Capacity, 1'b0);
      if (ph == 2) send_random_body(Capacity + 9, 1'b0);
      if (ph == 3) send_random_body(3, 1'b1);
      while (items_sent < 15 + 450 * (ph + 1)) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        send_random_body(n, 1'b0);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain and settle.
    while (props_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d particles in bodies of 1 to %0d, checked %0d body results.",
             items_sent, Capacity + 9, bodies_seen);
    $display("Covered zero mass, full and overfull stores, extremes and a long output stall.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### rigid_body_mass_properties.f
hdl/rbmp_pkg.sv
hdl/rbmp_ram.sv
hdl/rbmp_fifo.sv
hdl/rbmp_div.sv
hdl/rbmp_front.sv
hdl/rbmp_back.sv
hdl/rigid_body_mass_properties.sv
sim/tb.sv
